/* rtl/ffra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int MAX_SLOTS    = 4096;
    localparam int MAX_SEGMENTS = 64;
    localparam int RESET_POOL   = 4096;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic        func;
        logic [12:0] range_count;
        logic [11:0] free_start;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] alloc_start;
    } rsp_t;

    typedef struct packed {
        logic init;
        logic load;
        logic scan;
        logic pick;
        logic decide;
        logic apply;
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_PICK   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_APPLY  = 5'b10000
    } state_t;

endpackage

/* rtl/first_fit_range_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit slot allocator over a sorted, coalescing free-segment table.
// ----------------------------------------------------------------------------
// done rises once the apply step has run; rsp is valid while it is high.
// A new transaction is taken only from idle (busy low), so each one runs through the
// four-step compare/pick/shift sequence over the segment cells before the next.
// Reset: one free segment covering min(4096, MAX_SLOTS) slots; a capacity write
// rebuilds the table in its write cycle. Results cannot be stalled.
module first_fit_range_allocator #(
    parameter int MAX_SLOTS    = ffra_pkg::MAX_SLOTS,
    parameter int MAX_SEGMENTS = ffra_pkg::MAX_SEGMENTS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ffra_pkg::req_t req,
    output logic           done,
    output ffra_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [12:0]    cfg_data
);

    ffra_pkg::cmd_t cmd;

    ffra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    ffra_datapath #(
        .MAX_SLOTS    (MAX_SLOTS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_data (cfg_data),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

/* rtl/ffra_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: accepts a transaction or a capacity write and steps the
// datapath through scan, pick, decide and apply.
// ----------------------------------------------------------------------------
module ffra_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           cfg_valid,
    output logic           busy,
    output logic           cfg_ready,
    output ffra_pkg::cmd_t cmd
);

    ffra_pkg::state_t state_reg;
    ffra_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffra_pkg::S_IDLE:
            begin
                if (start)
                    state_next = ffra_pkg::S_SCAN;
            end
            ffra_pkg::S_SCAN:   state_next = ffra_pkg::S_PICK;
            ffra_pkg::S_PICK:   state_next = ffra_pkg::S_DECIDE;
            ffra_pkg::S_DECIDE: state_next = ffra_pkg::S_APPLY;
            ffra_pkg::S_APPLY:  state_next = ffra_pkg::S_IDLE;
            default:            state_next = ffra_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ffra_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy      = (state_reg != ffra_pkg::S_IDLE);
    assign cfg_ready = (state_reg == ffra_pkg::S_IDLE) && !start;

    always_comb
    begin
        cmd        = '0;
        cmd.init   = cfg_valid && cfg_ready;
        cmd.load   = start && !busy;
        cmd.scan   = (state_reg == ffra_pkg::S_SCAN);
        cmd.pick   = (state_reg == ffra_pkg::S_PICK);
        cmd.decide = (state_reg == ffra_pkg::S_DECIDE);
        cmd.apply  = (state_reg == ffra_pkg::S_APPLY);
    end

    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");
    a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready)
        else $error("capacity write offered while busy");
    a_apply_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> !busy)
        else $error("apply not followed by idle");

endmodule

/* rtl/ffra_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_datapath
// Row of segment cells with parallel compare, priority pick and
// shift insert/remove; holds the pool size and the result register.
// ----------------------------------------------------------------------------
module ffra_datapath #(
    parameter int MAX_SLOTS    = ffra_pkg::MAX_SLOTS,
    parameter int MAX_SEGMENTS = ffra_pkg::MAX_SEGMENTS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ffra_pkg::cmd_t cmd,
    input  ffra_pkg::req_t req,
    input  logic [12:0]    cfg_data,
    output logic           done,
    output ffra_pkg::rsp_t rsp
);

    localparam int N  = MAX_SEGMENTS;
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int XW = (CW > 13) ? CW : 13;
    localparam int TW = $clog2(MAX_SEGMENTS + 1);
    localparam int RP = (ffra_pkg::RESET_POOL > MAX_SLOTS) ? MAX_SLOTS : ffra_pkg::RESET_POOL;

    logic [SW-1:0] start_reg [N];
    logic [CW-1:0] count_reg [N];
    logic [TW-1:0] total_reg;
    logic [CW-1:0] pool_reg;

    logic          func_reg;
    logic [XW-1:0] cnt_reg;
    logic [XW-1:0] fs_reg;

    logic [N-1:0]  fit_reg, before_reg;
    logic          drop_reg;
    logic [CW-1:0] ccnt_reg;
    logic [CW-1:0] endc_reg;

    logic [N-1:0]  fit_oh_reg;
    logic [N:0]    pos_oh_reg;

    logic [N-1:0]  upd_oh_reg, rm_mask_reg, ins_mask_reg;
    logic [SW-1:0] upd_start_reg;
    logic [CW-1:0] upd_count_reg;
    logic [TW-1:0] total_new_reg;
    ffra_pkg::rsp_t rsp_reg;
    logic          done_reg;

    ffra_pkg::rsp_t rsp_c_hold;
    ffra_pkg::rsp_t rsp_hold_reg;

    // scan: per-cell compares
    logic [N-1:0]  valid, fit_c, before_c;
    logic [XW:0]   end_raw;
    logic [XW:0]   pool_x;
    logic [CW-1:0] endc_c;

    always_comb
    begin
        pool_x  = (XW + 1)'(pool_reg);
        end_raw = {1'b0, fs_reg} + {1'b0, cnt_reg};
        endc_c  = (end_raw > pool_x) ? pool_reg : CW'(end_raw);
        for (int i = 0; i < N; i++)
        begin
            valid[i]    = (TW'(i) < total_reg);
            fit_c[i]    = valid[i] && (XW'(count_reg[i]) >= cnt_reg);
            before_c[i] = valid[i] && (XW'(start_reg[i]) < fs_reg);
        end
    end

    // pick: first fit and sorted insert position
    logic [N:0] b_ext;
    logic [N-1:0] fit_oh_c;
    logic [N:0] pos_oh_c;

    always_comb
    begin
        b_ext    = {1'b0, before_reg};
        fit_oh_c = fit_reg & (~fit_reg + 1'b1);
        pos_oh_c = ~b_ext & (b_ext + 1'b1);
    end

    // decide: gather picked cells and plan the update
    logic [SW-1:0] hit_start, next_start, prev_start;
    logic [CW-1:0] hit_count, next_count, prev_count, left_cnt;
    logic          next_valid, has_prev, join_next, join_prev;
    logic [CW:0]   prev_end;
    logic [N-1:0]  pos_lo, pos_prev, ge_fit, ge_pos;
    logic [N-1:0]  upd_oh_c, rm_c, ins_c;
    logic [SW-1:0] upd_start_c;
    logic [CW-1:0] upd_count_c;
    logic [TW-1:0] total_c;
    ffra_pkg::rsp_t rsp_c;

    always_comb
    begin
        hit_start  = '0;
        hit_count  = '0;
        next_start = '0;
        next_count = '0;
        prev_start = '0;
        prev_count = '0;
        next_valid = 1'b0;
        pos_lo     = pos_oh_reg[N-1:0];
        pos_prev   = pos_oh_reg[N:1];
        for (int i = 0; i < N; i++)
        begin
            hit_start  = hit_start  | (start_reg[i] & {SW{fit_oh_reg[i]}});
            hit_count  = hit_count  | (count_reg[i] & {CW{fit_oh_reg[i]}});
            next_start = next_start | (start_reg[i] & {SW{pos_lo[i]}});
            next_count = next_count | (count_reg[i] & {CW{pos_lo[i]}});
            prev_start = prev_start | (start_reg[i] & {SW{pos_prev[i]}});
            prev_count = prev_count | (count_reg[i] & {CW{pos_prev[i]}});
            next_valid = next_valid | (valid[i] & pos_lo[i]);
        end
        has_prev  = !pos_oh_reg[0];
        prev_end  = (CW + 1)'(prev_start) + (CW + 1)'(prev_count);
        join_next = next_valid && (CW'(next_start) == endc_reg);
        join_prev = has_prev && (prev_end == (CW + 1)'(fs_reg));
        left_cnt  = hit_count - CW'(cnt_reg);
        ge_fit    = ~(fit_oh_reg - 1'b1);
        ge_pos    = ~(pos_lo - 1'b1);

        upd_oh_c    = '0;
        rm_c        = '0;
        ins_c       = '0;
        upd_start_c = '0;
        upd_count_c = '0;
        total_c     = total_reg;
        rsp_c       = '0;
        rsp_c.status = ffra_pkg::ST_OK;

        if (cnt_reg == '0)
        begin
            rsp_c.status = ffra_pkg::ST_ZERO;
        end
        else if (func_reg == ffra_pkg::FUNC_ALLOC)
        begin
            if (fit_oh_reg == '0)
            begin
                rsp_c.status = ffra_pkg::ST_NOFIT;
            end
            else
            begin
                rsp_c.alloc_start = 12'(hit_start);
                if (left_cnt == '0)
                begin
                    rm_c    = ge_fit;
                    total_c = total_reg - 1'b1;
                end
                else
                begin
                    upd_oh_c    = fit_oh_reg;
                    upd_start_c = hit_start + SW'(cnt_reg);
                    upd_count_c = left_cnt;
                end
            end
        end
        else if (!drop_reg)
        begin
            if (join_next && join_prev)
            begin
                upd_oh_c    = pos_prev;
                upd_start_c = prev_start;
                upd_count_c = prev_count + ccnt_reg + next_count;
                rm_c        = ge_pos;
                total_c     = total_reg - 1'b1;
            end
            else if (join_next)
            begin
                upd_oh_c    = pos_lo;
                upd_start_c = SW'(fs_reg);
                upd_count_c = next_count + ccnt_reg;
            end
            else if (join_prev)
            begin
                upd_oh_c    = pos_prev;
                upd_start_c = prev_start;
                upd_count_c = prev_count + ccnt_reg;
            end
            else if (total_reg == TW'(N))
            begin
                rsp_c.status = ffra_pkg::ST_FULL;
            end
            else
            begin
                upd_oh_c    = pos_lo;
                upd_start_c = SW'(fs_reg);
                upd_count_c = ccnt_reg;
                ins_c       = ge_pos & ~pos_lo;
                total_c     = total_reg + 1'b1;
            end
        end
    end

    logic [12:0] cfg_sat;
    always_comb
    begin
        cfg_sat = ({19'b0, cfg_data} > 32'(MAX_SLOTS)) ? 13'(MAX_SLOTS) : cfg_data;
    end

    // request and stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg      <= ffra_pkg::FUNC_ALLOC;
            cnt_reg       <= '0;
            fs_reg        <= '0;
            fit_reg       <= '0;
            before_reg    <= '0;
            drop_reg      <= 1'b0;
            ccnt_reg      <= '0;
            endc_reg      <= '0;
            fit_oh_reg    <= '0;
            pos_oh_reg    <= '0;
            upd_oh_reg    <= '0;
            rm_mask_reg   <= '0;
            ins_mask_reg  <= '0;
            upd_start_reg <= '0;
            upd_count_reg <= '0;
            total_new_reg <= '0;
            rsp_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.apply;
            if (cmd.load)
            begin
                func_reg <= req.func;
                cnt_reg  <= XW'(req.range_count);
                fs_reg   <= XW'(req.free_start);
            end
            if (cmd.scan)
            begin
                fit_reg    <= fit_c;
                before_reg <= before_c;
                drop_reg   <= (fs_reg >= XW'(pool_reg));
                endc_reg   <= endc_c;
                ccnt_reg   <= endc_c - CW'(fs_reg);
            end
            if (cmd.pick)
            begin
                fit_oh_reg <= fit_oh_c;
                pos_oh_reg <= pos_oh_c;
            end
            if (cmd.decide)
            begin
                upd_oh_reg    <= upd_oh_c;
                rm_mask_reg   <= rm_c;
                ins_mask_reg  <= ins_c;
                upd_start_reg <= upd_start_c;
                upd_count_reg <= upd_count_c;
                total_new_reg <= total_c;
            end
            if (cmd.apply)
                rsp_reg <= rsp_c_hold;
        end
    end

    // hold the decided response until apply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_hold_reg <= '0;
        else if (cmd.decide)
            rsp_hold_reg <= rsp_c;
    end
    assign rsp_c_hold = rsp_hold_reg;

    // segment cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg  <= CW'(RP);
            total_reg <= (RP != 0) ? TW'(1) : TW'(0);
            for (int i = 0; i < N; i++)
            begin
                start_reg[i] <= '0;
                count_reg[i] <= (i == 0) ? CW'(RP) : '0;
            end
        end
        else if (cmd.init)
        begin
            pool_reg  <= CW'(cfg_sat);
            total_reg <= (cfg_sat != '0) ? TW'(1) : TW'(0);
            for (int i = 0; i < N; i++)
            begin
                start_reg[i] <= '0;
                count_reg[i] <= (i == 0) ? CW'(cfg_sat) : '0;
            end
        end
        else if (cmd.apply)
        begin
            total_reg <= total_new_reg;
            for (int i = 0; i < N; i++)
            begin
                if (upd_oh_reg[i])
                begin
                    start_reg[i] <= upd_start_reg;
                    count_reg[i] <= upd_count_reg;
                end
                else if (rm_mask_reg[i])
                begin
                    // pull the next cell down; the last cell empties
                    start_reg[i] <= (i == N - 1) ? '0 : start_reg[(i + 1) % N];
                    count_reg[i] <= (i == N - 1) ? '0 : count_reg[(i + 1) % N];
                end
                else if (ins_mask_reg[i])
                begin
                    start_reg[i] <= start_reg[(i + N - 1) % N];
                    count_reg[i] <= count_reg[(i + N - 1) % N];
                end
            end
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TW'(N))
        else $error("segment total beyond table depth");
    a_upd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(upd_oh_reg))
        else $error("more than one cell updated");
    a_masks_apart: assert property (@(posedge clk) disable iff (!rst_n)
        ((upd_oh_reg & rm_mask_reg) == '0) && ((rm_mask_reg & ins_mask_reg) == '0))
        else $error("update, remove and insert overlap");
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply && !cmd.init |=> (total_reg == $past(total_new_reg)))
        else $error("segment total not taken from plan");

endmodule
